// File: rtl/ahp_priority_vector_macros.svh
// Assertion macros shared by the priority vector RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef AHP_PRIORITY_VECTOR_MACROS_SVH
`define AHP_PRIORITY_VECTOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define AHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define AHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ahp_pkg.sv
// Shared types and constants for the priority vector block.
// No dependencies; used by ahp_ctrl, ahp_dp and ahp_priority_vector.
package ahp_pkg;

    localparam int ELEM_W       = 24;
    localparam int SUM_W        = 28;
    localparam int SIZE_W       = 5;
    localparam int INDEX_W      = 4;
    localparam int WEIGHT_W     = 17;
    localparam int FRAC_W       = 16;
    localparam int MAX_SIZE_DEF = 16;

    localparam logic [SIZE_W-1:0]   SIZE_RESET = 5'd4;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    typedef enum logic [7:0] {
        ST_LOAD  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_EINIT = 8'b0000_0100,
        ST_EDIV  = 8'b0000_1000,
        ST_EACC  = 8'b0001_0000,
        ST_NINIT = 8'b0010_0000,
        ST_NDIV  = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } ahp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic elem_init;
        logic div_step;
        logic accum;
        logic norm_init;
        logic emit;
    } ahp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_col;
        logic last_row;
        logic div_skip;
    } ahp_sts_t;

endpackage

// File: rtl/ahp_priority_vector.sv
// Priority vector from a pairwise comparison matrix (column-normalized row means).
// Flow: one element per cycle while loading; then per row each element is divided by its
// column sum (skipped if that sum is zero or not above the element), and the row total by
// n, on the shared one-bit-per-cycle divider; one weight word per row.
// Throughput: one matrix at a time; start is ignored while busy; results cannot be stalled.
// Reset: size 4, column sums and counters cleared. Depends on ahp_pkg, ahp_ctrl and ahp_dp.

module ahp_priority_vector
    import ahp_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SIZE_W-1:0]   matrix_size,
    input  logic                start,
    output logic                busy,
    input  logic [ELEM_W-1:0]   element_value,
    output logic                done,
    output logic [INDEX_W-1:0]  weight_index,
    output logic [WEIGHT_W-1:0] weight_value,
    output logic                last_weight,
    output logic                zero_column_seen
);

    ahp_cmd_t cmd;
    ahp_sts_t sts;
    logic     cfg_we;

    // Take size writes only while idle and no element word is offered
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;

    ahp_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    ahp_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_size         (matrix_size),
        .cmd              (cmd),
        .sts              (sts),
        .elem_in          (element_value),
        .weight_index     (weight_index),
        .weight_value     (weight_value),
        .last_weight      (last_weight),
        .zero_column_seen (zero_column_seen)
    );

endmodule

// File: rtl/ahp_ctrl.sv
// Sequencer for load, bit-serial divisions and weight output.
// Depends on ahp_pkg and ahp_priority_vector_macros.svh.
`include "ahp_priority_vector_macros.svh"

module ahp_ctrl
    import ahp_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output ahp_cmd_t cmd,
    input  ahp_sts_t sts
);

    localparam int TW = WEIGHT_W + $clog2(MAX_SIZE);
    localparam int CW = $clog2(TW);

    ahp_state_t       state_reg, state_next;
    logic [CW-1:0]    step_reg, step_next;

    // Hold state and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Decode next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.last_row && sts.last_col)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EINIT;
            end
            ST_EINIT:
            begin
                cmd.elem_init = 1'b1;
                step_next     = '0;
                state_next    = sts.div_skip ? ST_EACC : ST_EDIV;
            end
            ST_EDIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == CW'(FRAC_W - 1))
                begin
                    state_next = ST_EACC;
                end
            end
            ST_EACC:
            begin
                cmd.accum  = 1'b1;
                state_next = sts.last_col ? ST_NINIT : ST_READ;
            end
            ST_NINIT:
            begin
                cmd.norm_init = 1'b1;
                step_next     = '0;
                state_next    = ST_NDIV;
            end
            ST_NDIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == CW'(TW - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                done       = 1'b1;
                state_next = sts.last_row ? ST_LOAD : ST_READ;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign busy = (state_reg != ST_LOAD);

    `AHP_ASSERT_NEXT(a_last_word_idle, done && sts.last_row, !busy,
        "block not idle after final weight")
    `AHP_ASSERT_NEXT(a_final_elem_busy, start && !busy && sts.last_row && sts.last_col, busy,
        "final element did not start computation")
    `AHP_ASSERT_NEXT(a_div_length, (state_reg == ST_EDIV) && (step_reg != CW'(FRAC_W - 1)),
        state_reg == ST_EDIV, "element division ended early")

endmodule

// File: rtl/ahp_dp.sv
// Datapath: matrix store, column sums, shared bit-serial divider, row totals.
// Depends on ahp_pkg and ahp_priority_vector_macros.svh.
`include "ahp_priority_vector_macros.svh"

module ahp_dp
    import ahp_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SIZE_W-1:0]   cfg_size,
    input  ahp_cmd_t            cmd,
    output ahp_sts_t            sts,
    input  logic [ELEM_W-1:0]   elem_in,
    output logic [INDEX_W-1:0]  weight_index,
    output logic [WEIGHT_W-1:0] weight_value,
    output logic                last_weight,
    output logic                zero_column_seen
);

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = WEIGHT_W + $clog2(MAX_SIZE);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] n_eff;
    logic [SIZE_W-1:0] n_m1;
    logic [IW-1:0]     row_reg;
    logic [IW-1:0]     col_reg;
    logic [SUM_W-1:0]  colsum_reg [MAX_SIZE];
    logic [SUM_W-1:0]  colsum_sel;
    logic [TW-1:0]     total_reg;
    logic              zero_reg;
    logic [AW-1:0]     addr;
    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;
    logic [SUM_W-1:0]  elem_ext;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  divisor_reg;
    logic [TW-1:0]     quo_reg;
    logic [SUM_W:0]    trial;
    logic              q_bit;
    logic [SUM_W-1:0]  rem_next;
    logic              last_col;
    logic              last_row;

    // Clamp the size register to the supported range
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            n_eff = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign n_m1       = n_eff - SIZE_W'(1);
    assign last_col   = (SIZE_W'(col_reg) == n_m1);
    assign last_row   = (SIZE_W'(row_reg) == n_m1);
    assign colsum_sel = colsum_reg[col_reg];
    assign addr       = AW'(row_reg) * AW'(MAX_SIZE) + AW'(col_reg);
    assign elem_ext   = SUM_W'(rdata_reg);

    assign sts.last_col = last_col;
    assign sts.last_row = last_row;
    assign sts.div_skip = (colsum_sel == '0) || (elem_ext >= colsum_sel);

    // Advance counters, column sums, row total and zero flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= SIZE_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            total_reg <= '0;
            zero_reg  <= 1'b0;
            for (int i = 0; i < MAX_SIZE; i++)
            begin
                colsum_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            // New size drops any partial matrix
            size_reg  <= cfg_size;
            row_reg   <= '0;
            col_reg   <= '0;
            total_reg <= '0;
            zero_reg  <= 1'b0;
            for (int i = 0; i < MAX_SIZE; i++)
            begin
                colsum_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                colsum_reg[col_reg] <= colsum_reg[col_reg] + SUM_W'(elem_in);
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (cmd.elem_init && (colsum_sel == '0))
            begin
                zero_reg <= 1'b1;
            end
            if (cmd.accum)
            begin
                total_reg <= total_reg + quo_reg;
                col_reg   <= last_col ? '0 : col_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                total_reg <= '0;
                if (last_row)
                begin
                    // End of run: clear for the next matrix
                    row_reg  <= '0;
                    zero_reg <= 1'b0;
                    for (int i = 0; i < MAX_SIZE; i++)
                    begin
                        colsum_reg[i] <= '0;
                    end
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
        end
    end

    // Matrix store: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load && !cfg_we)
        begin
            mem[addr] <= elem_in;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // One restoring-division step: shift in the next dividend bit
    assign trial    = {rem_reg, quo_reg[TW-1]};
    assign q_bit    = (trial >= {1'b0, divisor_reg});
    assign rem_next = q_bit ? SUM_W'(trial - {1'b0, divisor_reg}) : SUM_W'(trial);

    // Load or step the shared divider
    always_ff @(posedge clk)
    begin
        if (cmd.elem_init)
        begin
            divisor_reg <= colsum_sel;
            rem_reg     <= elem_ext;
            if ((colsum_sel != '0) && (elem_ext >= colsum_sel))
            begin
                quo_reg <= TW'(WEIGHT_ONE);
            end
            else
            begin
                quo_reg <= '0;
            end
        end
        else if (cmd.norm_init)
        begin
            divisor_reg <= SUM_W'(n_eff);
            rem_reg     <= '0;
            quo_reg     <= total_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[TW-2:0], q_bit};
        end
    end

    assign weight_index     = INDEX_W'(row_reg);
    assign weight_value     = quo_reg[WEIGHT_W-1:0];
    assign last_weight      = last_row;
    assign zero_column_seen = zero_reg;

    `AHP_ASSERT_NEXT(a_rem_bound, cmd.div_step, rem_reg < divisor_reg,
        "divider remainder not below divisor")
    `AHP_ASSERT_NOW(a_weight_bound, cmd.emit, quo_reg <= TW'(WEIGHT_ONE),
        "weight above one")
    `AHP_ASSERT_NEXT(a_cfg_clears_flag, cfg_we, !zero_reg,
        "zero-column flag survived size write")

endmodule
